FILE: hw/rtl/klc_pkg.sv
// Shared types and constants for the keypad code lock.
package klc_pkg;

  localparam int unsigned CODE_LENGTH = 4;
  localparam int unsigned KEY_W       = 8;
  localparam int unsigned CODE_W      = CODE_LENGTH * KEY_W;
  localparam int unsigned COUNT_W     = $clog2(CODE_LENGTH);

  localparam logic [CODE_W-1:0] CHANGE_RESET   = 32'h2A30_3723;  // "*07#"
  localparam logic [CODE_W-1:0] PASSWORD_RESET = 32'h3935_3230;  // "9520"

  typedef enum logic [1:0] {
    MODE_ENTRY = 2'd0,
    MODE_OLD   = 2'd1,
    MODE_NEW   = 2'd2
  } lock_mode_e;

  typedef enum logic [2:0] {
    ST_TAKEN     = 3'd0,
    ST_GRANTED   = 3'd1,
    ST_DENIED    = 3'd2,
    ST_CHANGE    = 3'd3,
    ST_OLD_WRONG = 3'd4,
    ST_OLD_OK    = 3'd5,
    ST_STORED    = 3'd6
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] keys_held;
  } result_t;

endpackage

FILE: hw/rtl/klc_core.sv
// Lock state: entry buffer, key count, mode, password and the per-key decision.
module klc_core import klc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic              cfg_we_i,
  input  logic [CODE_W-1:0] cfg_wdata_i,
  output result_t           result_o
);

  lock_mode_e         mode_q, mode_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [CODE_W-1:0]  pass_q, pass_d;
  logic [CODE_W-1:0]  change_q;
  logic [KEY_W-1:0]   buf_q [CODE_LENGTH-1];
  logic [CODE_W-1:0]  entry;
  logic               last_key;
  logic               pass_hit;
  logic               change_hit;
  status_e            status;

  // The closing key completes the word without passing through the buffer.
  always_comb begin
    entry = '0;
    for (int k = 0; k < CODE_LENGTH - 1; k++) begin
      entry[CODE_W-1-k*KEY_W -: KEY_W] = buf_q[k];
    end
    entry[KEY_W-1:0] = key_i;
  end

  assign last_key   = (count_q == COUNT_W'(CODE_LENGTH - 1));
  assign pass_hit   = (entry == pass_q);
  assign change_hit = (entry == change_q);

  // next state
  always_comb begin
    mode_d  = mode_q;
    pass_d  = pass_q;
    count_d = last_key ? '0 : count_q + 1'b1;
    if (last_key) begin
      unique case (mode_q)
        MODE_OLD: begin
          mode_d = pass_hit ? MODE_NEW : MODE_ENTRY;
        end
        MODE_NEW: begin
          pass_d = entry;
          mode_d = MODE_ENTRY;
        end
        default: begin
          mode_d = (!pass_hit && change_hit) ? MODE_OLD : MODE_ENTRY;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    status = ST_TAKEN;
    if (last_key) begin
      unique case (mode_q)
        MODE_OLD: status = pass_hit ? ST_OLD_OK : ST_OLD_WRONG;
        MODE_NEW: status = ST_STORED;
        default: begin
          if (pass_hit)        status = ST_GRANTED;
          else if (change_hit) status = ST_CHANGE;
          else                 status = ST_DENIED;
        end
      endcase
    end
  end

  assign result_o.status    = status;
  assign result_o.keys_held = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ENTRY;
      count_q  <= '0;
      pass_q   <= PASSWORD_RESET;
      change_q <= CHANGE_RESET;
    end else begin
      if (fire_i) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        pass_q  <= pass_d;
      end
      if (cfg_we_i) begin
        change_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && !last_key) begin
      buf_q[count_q] <= key_i;
    end
  end

endmodule

FILE: hw/rtl/klc_out_reg.sv
// Result register holding one word until the downstream side takes it.
module klc_out_reg import klc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    stall_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign ready_o  = !valid_q || !stall_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: hw/rtl/keypad_code_lock_with_change_unit.sv
// Keypad code lock with password change: input register, decision logic, result register.
// Path: a key goes from the input register through the core to the result register.
// Throughput: one key per cycle while the output side is not stalled.
// Reset: mode normal entry, no keys held, password "9520", change code "*07#";
// the entry buffer is not reset.
module keypad_code_lock_with_change_unit import klc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              key_valid_i,
  output logic              key_stall_o,
  input  logic [KEY_W-1:0]  key_char_i,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output logic [2:0]        status_o,
  output logic [COUNT_W-1:0] keys_held_o,
  input  logic              cfg_we_i,
  input  logic [CODE_W-1:0] cfg_wdata_i
);

  logic             in_valid_q;
  logic [KEY_W-1:0] key_q;
  logic             out_ready;
  logic             fire;
  logic             accept;
  result_t          core_res;
  result_t          out_res;

  assign fire        = in_valid_q && out_ready;
  assign key_stall_o = in_valid_q && !out_ready;
  assign accept      = key_valid_i && !key_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!key_stall_o) begin
      in_valid_q <= key_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_char_i;
    end
  end

  klc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .key_i       (key_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (core_res)
  );

  klc_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (core_res),
    .stall_i  (res_stall_i),
    .ready_o  (out_ready),
    .valid_o  (res_valid_o),
    .result_o (out_res)
  );

  assign status_o    = out_res.status;
  assign keys_held_o = out_res.keys_held;

endmodule
